[rtl/blf_pkg.sv]
// ----------------------------------------------------------------------------
// blf_pkg
// Shared types and constants of the byte stream line framer.
// ----------------------------------------------------------------------------
package blf_pkg;

  localparam int MAX_HEADER_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CNT_W = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] MODE_CHUNK = 3'd0;
  localparam logic [2:0] MODE_DELIM = 3'd1;
  localparam logic [2:0] MODE_FIXED = 3'd2;
  localparam logic [2:0] MODE_TLV   = 3'd3;
  localparam logic [2:0] MODE_CRLF  = 3'd4;

  localparam logic [2:0] REG_SPLIT_MODE   = 3'd0;
  localparam logic [2:0] REG_SPLIT_VALUE  = 3'd1;
  localparam logic [2:0] REG_HEADER_BYTES = 3'd2;
  localparam logic [2:0] REG_LENGTH_POS   = 3'd3;
  localparam logic [2:0] REG_LENGTH_WIDE  = 3'd4;

  localparam logic [15:0] FIXED_LEN_DEF = 16'd16;
  localparam logic [7:0]  CHAR_CR       = 8'h0D;
  localparam logic [7:0]  CHAR_LF       = 8'h0A;

  typedef struct packed {
    logic [2:0]  split_mode;
    logic [15:0] split_value;
    logic [4:0]  header_bytes;
    logic [3:0]  length_position;
    logic        length_is_wide;
    logic        clear;
  } cfg_t;

  typedef struct packed {
    logic       carries_byte;
    logic [7:0] out_byte;
    logic       out_direction;
    logic       opens_line;
    logic       closes_line;
  } res_t;

  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

endpackage

[rtl/blf_if.sv]
// ----------------------------------------------------------------------------
// blf_in_if / blf_out_if
// Valid/ready channels for input bytes and framed results.
// ----------------------------------------------------------------------------
interface blf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_direction;
  logic       chunk_final;

  modport source (output valid, output in_byte, output in_direction,
                  output chunk_final, input ready);
  modport sink (input valid, input in_byte, input in_direction,
                input chunk_final, output ready);
endinterface

interface blf_out_if;
  logic       valid;
  logic       ready;
  logic       carries_byte;
  logic [7:0] out_byte;
  logic       out_direction;
  logic       opens_line;
  logic       closes_line;

  modport source (output valid, output carries_byte, output out_byte,
                  output out_direction, output opens_line, output closes_line,
                  input ready);
  modport sink (input valid, input carries_byte, input out_byte,
                input out_direction, input opens_line, input closes_line,
                output ready);
endinterface

[rtl/blf_cfg.sv]
// ----------------------------------------------------------------------------
// blf_cfg
// APB register file; a write to a known register also clears line state.
// ----------------------------------------------------------------------------
module blf_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [blf_pkg::ADDR_W-1:0] paddr,
  input  logic [blf_pkg::DATA_W-1:0] pwdata,
  output logic [blf_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output blf_pkg::cfg_t              cfg
);
  import blf_pkg::*;

  logic [2:0]  mode_r;
  logic [15:0] value_r;
  logic [4:0]  hdr_r;
  logic [3:0]  pos_r;
  logic        wide_r;
  logic [2:0]  idx;
  logic        wr;
  logic        known;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign known  = (idx <= REG_LENGTH_WIDE);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_CHUNK;
      value_r <= '0;
      hdr_r   <= 5'd1;
      pos_r   <= '0;
      wide_r  <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_SPLIT_MODE:   mode_r  <= pwdata[2:0];
        REG_SPLIT_VALUE:  value_r <= pwdata[15:0];
        REG_HEADER_BYTES: hdr_r   <= pwdata[4:0];
        REG_LENGTH_POS:   pos_r   <= pwdata[3:0];
        REG_LENGTH_WIDE:  wide_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SPLIT_MODE:   prdata = DATA_W'(mode_r);
      REG_SPLIT_VALUE:  prdata = DATA_W'(value_r);
      REG_HEADER_BYTES: prdata = DATA_W'(hdr_r);
      REG_LENGTH_POS:   prdata = DATA_W'(pos_r);
      REG_LENGTH_WIDE:  prdata = DATA_W'(wide_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.split_mode      = mode_r;
  assign cfg.split_value     = value_r;
  assign cfg.header_bytes    = hdr_r;
  assign cfg.length_position = pos_r;
  assign cfg.length_is_wide  = wide_r;
  assign cfg.clear           = wr && known;

endmodule

[rtl/blf_front.sv]
// ----------------------------------------------------------------------------
// blf_front
// Accept bytes, track the open line and decide line ends; emit queue entries.
// ----------------------------------------------------------------------------
module blf_front #(
  parameter int MAX_HEADER = blf_pkg::MAX_HEADER_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  blf_pkg::cfg_t   cfg,
  blf_in_if.sink          in_bus,
  input  logic            q_full,
  output logic            push,
  output blf_pkg::entry_t push_entry
);
  import blf_pkg::*;

  logic             open_r, open_nxt;
  logic             dir_r, dir_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             known_r, known_nxt;
  logic [CNT_W-1:0] target_r, target_nxt;
  logic             cr_r, cr_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic [7:0]       lo_r, lo_nxt;

  logic             accept;
  logic [7:0]       b;
  logic             dir_chg;
  logic             open0;
  logic [CNT_W-1:0] count0;
  logic             known0;
  logic [CNT_W-1:0] target0;
  logic             take_byte;
  logic             crlf_close;
  logic             opens;
  logic             line_dir;
  logic [CNT_W-1:0] count_new;
  logic [CNT_W-1:0] hb;
  logic [CNT_W-1:0] hdr;
  logic [CNT_W-1:0] pos;
  logic [7:0]       hi_v;
  logic [7:0]       lo_v;
  logic [15:0]      plen;
  logic             tlv_known;
  logic [CNT_W-1:0] tlv_target;
  logic [15:0]      flen;
  logic             closes;
  res_t             mark;
  res_t             byte_res;
  res_t             second;

  assign accept       = in_bus.valid && in_bus.ready;
  assign in_bus.ready = !q_full;
  assign b            = in_bus.in_byte;

  always_comb begin
    dir_chg = open_r && (in_bus.in_direction != dir_r);
    open0   = open_r && !dir_chg;
    count0  = dir_chg ? '0 : count_r;
    known0  = known_r && !dir_chg;
    target0 = dir_chg ? '0 : target_r;

    mark.carries_byte  = 1'b0;
    mark.out_byte      = '0;
    mark.out_direction = dir_r;
    mark.opens_line    = 1'b0;
    mark.closes_line   = 1'b1;

    take_byte  = 1'b1;
    crlf_close = 1'b0;
    cr_nxt     = cr_r;
    if (cfg.split_mode == MODE_CRLF) begin
      if (b == CHAR_LF && cr_r) begin
        cr_nxt    = 1'b0;
        take_byte = 1'b0;
      end else begin
        cr_nxt = (b == CHAR_CR);
        if (b == CHAR_CR || b == CHAR_LF) begin
          take_byte  = 1'b0;
          crlf_close = open0;
        end
      end
    end

    opens     = !open0;
    line_dir  = opens ? in_bus.in_direction : dir_r;
    count_new = (count0 != CNT_MAX) ? count0 + CNT_W'(1) : count0;

    hb = CNT_W'(cfg.header_bytes);
    if (hb == '0) begin
      hdr = CNT_W'(1);
    end else if (hb > CNT_W'(MAX_HEADER)) begin
      hdr = CNT_W'(MAX_HEADER);
    end else begin
      hdr = hb;
    end
    pos = CNT_W'(cfg.length_position);
    if (pos > hdr - CNT_W'(1)) begin
      pos = hdr - CNT_W'(1);
    end

    hi_v = (count0 == pos) ? b : hi_r;
    if (pos + CNT_W'(1) < hdr) begin
      lo_v = (count0 == pos + CNT_W'(1)) ? b : lo_r;
    end else begin
      lo_v = '0;
    end
    plen = cfg.length_is_wide ? {hi_v, lo_v} : {8'h00, hi_v};

    tlv_known  = known0;
    tlv_target = target0;
    if (!known0 && count_new >= hdr) begin
      tlv_known  = 1'b1;
      tlv_target = hdr + CNT_W'(plen);
    end

    flen = (cfg.split_value != '0) ? cfg.split_value : FIXED_LEN_DEF;

    unique case (cfg.split_mode)
      MODE_DELIM: closes = (b == cfg.split_value[7:0]);
      MODE_FIXED: closes = (count_new >= CNT_W'(flen));
      MODE_TLV:   closes = tlv_known && (tlv_target != '0) && (count_new >= tlv_target);
      MODE_CRLF:  closes = 1'b0;
      default:    closes = in_bus.chunk_final;
    endcase

    byte_res.carries_byte  = 1'b1;
    byte_res.out_byte      = b;
    byte_res.out_direction = line_dir;
    byte_res.opens_line    = opens;
    byte_res.closes_line   = closes;

    open_nxt   = open0;
    dir_nxt    = dir_r;
    count_nxt  = count0;
    known_nxt  = known0;
    target_nxt = target0;
    hi_nxt     = hi_r;
    lo_nxt     = lo_r;
    if (crlf_close) begin
      open_nxt   = 1'b0;
      count_nxt  = '0;
      known_nxt  = 1'b0;
      target_nxt = '0;
    end
    if (take_byte) begin
      dir_nxt = line_dir;
      hi_nxt  = (count0 == pos) ? b : hi_r;
      lo_nxt  = (count0 == pos + CNT_W'(1)) ? b : lo_r;
      if (closes) begin
        open_nxt   = 1'b0;
        count_nxt  = '0;
        known_nxt  = 1'b0;
        target_nxt = '0;
      end else begin
        open_nxt  = 1'b1;
        count_nxt = count_new;
        if (cfg.split_mode == MODE_TLV) begin
          known_nxt  = tlv_known;
          target_nxt = tlv_target;
        end
      end
    end

    second = take_byte ? byte_res : mark;
    if (dir_chg) begin
      push_entry.two = take_byte || crlf_close;
      push_entry.r0  = mark;
      push_entry.r1  = second;
    end else begin
      push_entry.two = 1'b0;
      push_entry.r0  = second;
      push_entry.r1  = second;
    end
    push = accept && (dir_chg || take_byte || crlf_close);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg.clear) begin
      open_r   <= 1'b0;
      dir_r    <= 1'b0;
      count_r  <= '0;
      known_r  <= 1'b0;
      target_r <= '0;
      cr_r     <= 1'b0;
    end else if (accept) begin
      open_r   <= open_nxt;
      dir_r    <= dir_nxt;
      count_r  <= count_nxt;
      known_r  <= known_nxt;
      target_r <= target_nxt;
      cr_r     <= cr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

endmodule

[rtl/blf_fifo.sv]
// ----------------------------------------------------------------------------
// blf_fifo
// Short queue of result entries between the front and back parts.
// ----------------------------------------------------------------------------
module blf_fifo #(
  parameter int DEPTH = blf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  blf_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output blf_pkg::entry_t head
);
  import blf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  entry_t          mem_r [DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt;
  logic [PW-1:0]   rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_nxt  = do_push ? ((wr_r == LAST) ? '0 : wr_r + PW'(1)) : wr_r;
    rd_nxt  = do_pop ? ((rd_r == LAST) ? '0 : rd_r + PW'(1)) : rd_r;
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

endmodule

[rtl/blf_back.sv]
// ----------------------------------------------------------------------------
// blf_back
// Unpack entries into registered results, one per cycle while out_bus is ready.
// ----------------------------------------------------------------------------
module blf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  blf_pkg::entry_t head,
  output logic            pop,
  blf_out_if.source       out_bus
);
  import blf_pkg::*;

  logic valid_r, valid_nxt;
  logic sel_r, sel_nxt;
  res_t res_r;
  logic load;

  always_comb begin
    load      = head_valid && (!valid_r || out_bus.ready);
    pop       = load && (sel_r || !head.two);
    sel_nxt   = load ? (!sel_r && head.two) : sel_r;
    valid_nxt = load ? 1'b1 : (out_bus.ready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= sel_r ? head.r1 : head.r0;
    end
  end

  assign out_bus.valid         = valid_r;
  assign out_bus.carries_byte  = res_r.carries_byte;
  assign out_bus.out_byte      = res_r.out_byte;
  assign out_bus.out_direction = res_r.out_direction;
  assign out_bus.opens_line    = res_r.opens_line;
  assign out_bus.closes_line   = res_r.closes_line;

endmodule

[rtl/byte_stream_line_framer.sv]
// ----------------------------------------------------------------------------
// byte_stream_line_framer
// Cut a direction-tagged byte stream into lines by chunk, delimiter, count,
// TLV length or CR/LF.
//
//   channel   kind          items
//   in_bus    valid/ready   one byte with direction and chunk end
//   out_bus   valid/ready   line byte or bare line end marker
//   cfg       APB write     split mode and TLV layout
//
// One byte accepted per cycle; up to two results per byte, one per cycle out
// while out_bus.ready is high; a result passes the queue, then the output reg.
// in_bus.ready drops only while the result queue is full.
// Reset is synchronous; no clearing pass. Writes to known registers clear line state.
// ----------------------------------------------------------------------------
module byte_stream_line_framer #(
  parameter int MAX_HEADER  = blf_pkg::MAX_HEADER_DEF,
  parameter int QUEUE_DEPTH = blf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  blf_in_if.sink                     in_bus,
  blf_out_if.source                  out_bus,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [blf_pkg::ADDR_W-1:0] paddr,
  input  logic [blf_pkg::DATA_W-1:0] pwdata,
  output logic [blf_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import blf_pkg::*;

  cfg_t   cfg;
  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   pop;
  logic   head_valid;
  entry_t head;

  blf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  blf_front #(.MAX_HEADER(MAX_HEADER)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_bus     (in_bus),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  blf_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  blf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_bus    (out_bus)
  );

endmodule

[rtl/blf_checker.sv]
// ----------------------------------------------------------------------------
// blf_checker
// Port-level checks of the line framer, bound to the top level.
// ----------------------------------------------------------------------------
module blf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       carries_byte,
  input logic [7:0] out_byte,
  input logic       out_direction,
  input logic       opens_line,
  input logic       closes_line
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(carries_byte) && $stable(out_direction))
    else $error("result item changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !carries_byte |-> closes_line && !opens_line && out_byte == 8'h00)
    else $error("bare line end marker malformed");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("input ready dropped without an accepted item");

endmodule

bind byte_stream_line_framer blf_checker u_blf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_bus.valid),
  .in_ready      (in_bus.ready),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .carries_byte  (out_bus.carries_byte),
  .out_byte      (out_bus.out_byte),
  .out_direction (out_bus.out_direction),
  .opens_line    (out_bus.opens_line),
  .closes_line   (out_bus.closes_line)
);

[tb/byte_stream_line_framer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stream_line_framer_tb
// Drives direction-tagged bytes through every split mode and a range of register
// settings, predicts each line byte and line-end marker in the bench, and
// compares the results in order under random idling and long output stalls.
// ----------------------------------------------------------------------------
module byte_stream_line_framer_tb;
  import blf_pkg::*;

  localparam int LIMIT_CYCLES  = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 52;
  localparam int PHASE_COUNT   = 24;
  localparam int HOLD_CYCLES   = 400;

  localparam logic [2:0] MODE_UNUSED_TOP = 3'd7;

  typedef enum logic [1:0] {ROW_CFG, ROW_CHECKED, ROW_TYPED} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  reg_idx;
    logic [15:0] reg_val;
    logic [7:0]  b;
    logic        d;
    logic        fin;
    logic [1:0]  n_exp;
    res_t        e0;
    res_t        e1;
  } step_t;

  localparam res_t NO_RES = '0;

  localparam step_t DIRECTED_STEPS [30] = '{
    '{ROW_TYPED, 3'd0, 16'd0, 8'h00, 1'b0, 1'b0, 2'd1, '{1'b1, 8'h00, 1'b0, 1'b1, 1'b0}, NO_RES},
    '{ROW_TYPED, 3'd0, 16'd0, 8'hFF, 1'b0, 1'b1, 2'd1, '{1'b1, 8'hFF, 1'b0, 1'b0, 1'b1}, NO_RES},
    '{ROW_TYPED, 3'd0, 16'd0, 8'h41, 1'b1, 1'b0, 2'd1, '{1'b1, 8'h41, 1'b1, 1'b1, 1'b0}, NO_RES},
    '{ROW_TYPED, 3'd0, 16'd0, 8'h42, 1'b0, 1'b0, 2'd2, '{1'b0, 8'h00, 1'b1, 1'b0, 1'b1},
      '{1'b1, 8'h42, 1'b0, 1'b1, 1'b0}},
    '{ROW_TYPED, 3'd0, 16'd0, 8'h43, 1'b0, 1'b1, 2'd1, '{1'b1, 8'h43, 1'b0, 1'b0, 1'b1}, NO_RES},
    '{ROW_CFG, REG_SPLIT_MODE, 16'(MODE_UNUSED_TOP), 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_TYPED, 3'd0, 16'd0, 8'h80, 1'b1, 1'b1, 2'd1, '{1'b1, 8'h80, 1'b1, 1'b1, 1'b1}, NO_RES},
    '{ROW_CFG, REG_SPLIT_MODE, 16'(MODE_DELIM), 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_CFG, REG_SPLIT_VALUE, 16'hFF3B, 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_TYPED, 3'd0, 16'd0, 8'h3B, 1'b0, 1'b0, 2'd1, '{1'b1, 8'h3B, 1'b0, 1'b1, 1'b1}, NO_RES},
    '{ROW_CHECKED, 3'd0, 16'd0, 8'h01, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{ROW_CHECKED, 3'd0, 16'd0, 8'h3B, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_CFG, REG_SPLIT_MODE, 16'(MODE_FIXED), 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_CFG, REG_SPLIT_VALUE, 16'd2, 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_CHECKED, 3'd0, 16'd0, 8'h55, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_CHECKED, 3'd0, 16'd0, 8'hAA, 1'b1, 1'b1, 2'd0, NO_RES, NO_RES},
    '{ROW_CFG, REG_SPLIT_MODE, 16'(MODE_TLV), 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_CHECKED, 3'd0, 16'd0, 8'h02, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_CHECKED, 3'd0, 16'd0, 8'hAA, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{ROW_CHECKED, 3'd0, 16'd0, 8'hBB, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_CFG, REG_HEADER_BYTES, 16'd0, 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_TYPED, 3'd0, 16'd0, 8'h00, 1'b1, 1'b0, 2'd1, '{1'b1, 8'h00, 1'b1, 1'b1, 1'b1}, NO_RES},
    '{ROW_CFG, REG_SPLIT_MODE, 16'(MODE_CRLF), 8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_TYPED, 3'd0, 16'd0, 8'h61, 1'b0, 1'b0, 2'd1, '{1'b1, 8'h61, 1'b0, 1'b1, 1'b0}, NO_RES},
    '{ROW_TYPED, 3'd0, 16'd0, CHAR_CR, 1'b0, 1'b0, 2'd1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b1},
      NO_RES},
    '{ROW_TYPED, 3'd0, 16'd0, CHAR_LF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
    '{ROW_TYPED, 3'd0, 16'd0, CHAR_LF, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
    '{ROW_TYPED, 3'd0, 16'd0, 8'h62, 1'b1, 1'b0, 2'd1, '{1'b1, 8'h62, 1'b1, 1'b1, 1'b0}, NO_RES},
    '{ROW_TYPED, 3'd0, 16'd0, CHAR_CR, 1'b0, 1'b0, 2'd1, '{1'b0, 8'h00, 1'b1, 1'b0, 1'b1},
      NO_RES},
    '{ROW_TYPED, 3'd0, 16'd0, CHAR_LF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  blf_in_if  in_bus ();
  blf_out_if out_bus ();

  byte_stream_line_framer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // bench copy of the registers and line state
  logic [2:0]  mode_r;
  logic [15:0] value_r;
  logic [4:0]  hdr_r;
  logic [3:0]  pos_r;
  logic        wide_r;
  logic        open_q;
  logic        dir_q;
  logic [CNT_W-1:0] count_q;
  logic [7:0]  hdr_mem [MAX_HEADER_DEF];
  logic [CNT_W-1:0] target_q;
  logic        known_q;
  logic        cr_q;

  res_t line_results [$];

  logic item_typed;
  logic [1:0] item_n;
  res_t item_e0;
  res_t item_e1;

  int send_idle_pct;
  int recv_idle_pct = 0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int hold_left = 0;

  int errors = 0;
  int items_taken = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int cycle_count = 0;

  function automatic void end_line();
    open_q = 1'b0;
    count_q = '0;
    target_q = '0;
    known_q = 1'b0;
  endfunction

  function automatic void clear_state();
    end_line();
    dir_q = 1'b0;
    cr_q = 1'b0;
    for (int i = 0; i < MAX_HEADER_DEF; i++) hdr_mem[i] = 8'h00;
  endfunction

  function automatic void tlv_layout(output int hn, output int pn);
    if (hdr_r == 0) hn = 1;
    else if (int'(hdr_r) > MAX_HEADER_DEF) hn = MAX_HEADER_DEF;
    else hn = int'(hdr_r);
    pn = (int'(pos_r) > hn - 1) ? hn - 1 : int'(pos_r);
  endfunction

  function automatic int frame_byte(input logic [7:0] b, input logic d, input logic fin,
                                    output res_t r0, output res_t r1);
    res_t res [2];
    int n;
    int hn;
    int pn;
    logic opens;
    logic closes;
    logic [CNT_W-1:0] plen;
    n = 0;
    closes = 1'b0;
    res[0] = '0;
    res[1] = '0;
    if (open_q && d != dir_q) begin
      res[n] = '{1'b0, 8'h00, dir_q, 1'b0, 1'b1};
      n++;
      end_line();
    end
    if (mode_r == MODE_CRLF) begin
      if (b == CHAR_CR || b == CHAR_LF) begin
        if (b == CHAR_LF && cr_q) begin
          cr_q = 1'b0;
        end else begin
          cr_q = (b == CHAR_CR);
          if (open_q) begin
            res[n] = '{1'b0, 8'h00, dir_q, 1'b0, 1'b1};
            n++;
            end_line();
          end
        end
        r0 = res[0];
        r1 = res[1];
        return n;
      end
      cr_q = 1'b0;
    end
    opens = !open_q;
    if (opens) begin
      open_q = 1'b1;
      dir_q = d;
    end
    if (int'(count_q) < MAX_HEADER_DEF) hdr_mem[int'(count_q)] = b;
    if (count_q != CNT_MAX) count_q = count_q + 1'b1;
    case (mode_r)
      MODE_DELIM: closes = (b == value_r[7:0]);
      MODE_FIXED: closes = (count_q >= ((value_r != 0) ? value_r : FIXED_LEN_DEF));
      MODE_TLV: begin
        tlv_layout(hn, pn);
        if (!known_q && count_q >= CNT_W'(hn)) begin
          plen = CNT_W'(hdr_mem[pn]);
          if (wide_r) plen = {plen[8:0], (pn + 1 < hn) ? hdr_mem[pn + 1] : 8'h00};
          target_q = CNT_W'(hn) + plen;
          known_q = 1'b1;
        end
        closes = known_q && target_q != 0 && count_q >= target_q;
      end
      MODE_CRLF: closes = 1'b0;
      default: closes = fin;
    endcase
    res[n] = '{1'b1, b, dir_q, opens, closes};
    n++;
    if (closes) end_line();
    r0 = res[0];
    r1 = res[1];
    return n;
  endfunction

  function automatic string res_text(input res_t r);
    return $sformatf("carries=%0b byte=%02h dir=%0b opens=%0b closes=%0b",
                     r.carries_byte, r.out_byte, r.out_direction, r.opens_line, r.closes_line);
  endfunction

  always @(posedge clk) begin
    res_t want0;
    res_t want1;
    res_t got;
    int n;
    if (!rst_n) begin
      mode_r = MODE_CHUNK;
      value_r = 16'd0;
      hdr_r = 5'd1;
      pos_r = 4'd0;
      wide_r = 1'b0;
      clear_state();
    end else begin
      if (psel && penable && pwrite && pready
          && paddr[ADDR_W-1:2] <= REG_LENGTH_WIDE) begin
        case (paddr[ADDR_W-1:2])
          REG_SPLIT_MODE:   mode_r = pwdata[2:0];
          REG_SPLIT_VALUE:  value_r = pwdata[15:0];
          REG_HEADER_BYTES: hdr_r = pwdata[4:0];
          REG_LENGTH_POS:   pos_r = pwdata[3:0];
          REG_LENGTH_WIDE:  wide_r = pwdata[0];
          default: ;
        endcase
        clear_state();
      end
      if (in_bus.valid && in_bus.ready) begin
        n = frame_byte(in_bus.in_byte, in_bus.in_direction, in_bus.chunk_final, want0, want1);
        if (item_typed) begin
          n = int'(item_n);
          want0 = item_e0;
          want1 = item_e1;
        end
        if (n > 0) line_results.push_back(want0);
        if (n > 1) line_results.push_back(want1);
        items_taken++;
      end
      if (out_bus.valid && out_bus.ready) begin
        got = '{out_bus.carries_byte, out_bus.out_byte, out_bus.out_direction,
                out_bus.opens_line, out_bus.closes_line};
        if (line_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %s", $time, res_text(got));
        end else begin
          want0 = line_results.pop_front();
          results_checked++;
          if (got !== want0) begin
            errors++;
            $display("%0t: mismatch, expected %s, actual %s", $time, res_text(want0),
                     res_text(got));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: run timed out", $time);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic d, input logic fin,
                           input logic typed, input logic [1:0] n, input res_t e0,
                           input res_t e1);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.in_byte <= b;
    in_bus.in_direction <= d;
    in_bus.chunk_final <= fin;
    item_typed <= typed;
    item_n <= n;
    item_e0 <= e0;
    item_e1 <= e1;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(negedge clk); while (line_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  // header with a small length field, then payload; cut short now and then
  task automatic send_tlv_frame(input logic d, inout int sent);
    int hn;
    int pn;
    int plen;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] b;
    tlv_layout(hn, pn);
    hi = ($urandom_range(0, 15) == 0) ? 8'd1 : 8'd0;
    lo = 8'($urandom_range(0, 24));
    if (!wide_r) plen = int'(lo);
    else if (pn + 1 < hn) plen = int'(hi) * 256 + int'(lo);
    else plen = int'(hi) * 256;
    for (int k = 0; k < hn + plen; k++) begin
      if (k > 0 && $urandom_range(0, 59) == 0) break;
      if (k == pn) b = wide_r ? hi : lo;
      else if (wide_r && k == pn + 1 && k < hn) b = lo;
      else b = 8'($urandom_range(0, 255));
      send_item(b, d, 1'($urandom_range(0, 1)), 1'b0, 2'd0, NO_RES, NO_RES);
      sent++;
    end
  endtask

  initial begin
    logic [2:0]  mode_sel;
    logic [15:0] val_sel;
    logic [4:0]  hdr_sel;
    logic [3:0]  pos_sel;
    logic        wide_sel;
    logic        cur_dir;
    logic [7:0]  b;
    int sent;
    int pick;

    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.in_byte <= 8'h00;
    in_bus.in_direction <= 1'b0;
    in_bus.chunk_final <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    item_typed <= 1'b0;
    item_n <= 2'd0;
    item_e0 <= NO_RES;
    item_e1 <= NO_RES;
    send_idle_pct = 27;
    recv_idle_pct <= 84;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_STEPS[i]) begin
      if (DIRECTED_STEPS[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(DIRECTED_STEPS[i].reg_idx, DIRECTED_STEPS[i].reg_val);
      end else begin
        send_item(DIRECTED_STEPS[i].b, DIRECTED_STEPS[i].d, DIRECTED_STEPS[i].fin,
                  DIRECTED_STEPS[i].kind == ROW_TYPED, DIRECTED_STEPS[i].n_exp,
                  DIRECTED_STEPS[i].e0, DIRECTED_STEPS[i].e1);
      end
    end

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      wait_drained();
      if (ph == PHASE_COUNT / 3) begin
        send_idle_pct = 84;
        recv_idle_pct <= 27;
      end else if (ph == 2 * PHASE_COUNT / 3) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end

      mode_sel = (ph % 6 == 5) ? 3'($urandom_range(5, 7)) : 3'(ph % 6);
      val_sel = 16'($urandom_range(0, 65535));
      hdr_sel = 5'($urandom_range(0, 31));
      pos_sel = 4'($urandom_range(0, 15));
      wide_sel = 1'($urandom_range(0, 1));
      case (ph)
        1: val_sel = 16'h0000;
        7: val_sel = 16'hFFFF;
        2: val_sel = 16'd0;
        8: val_sel = 16'd1;
        14: val_sel = 16'($urandom_range(2, 40));
        20: val_sel = 16'hFFFF;
        3: begin
          hdr_sel = 5'd0;
          pos_sel = 4'd15;
          wide_sel = 1'b1;
        end
        9: begin
          hdr_sel = 5'd16;
          pos_sel = 4'd15;
          wide_sel = 1'b1;
        end
        15: begin
          hdr_sel = 5'd31;
          pos_sel = 4'd3;
          wide_sel = 1'b1;
        end
        21: begin
          hdr_sel = 5'($urandom_range(2, 8));
          wide_sel = 1'b0;
        end
        default: ;
      endcase
      write_reg(REG_SPLIT_MODE, 16'(mode_sel));
      write_reg(REG_SPLIT_VALUE, val_sel);
      write_reg(REG_HEADER_BYTES, 16'(hdr_sel));
      write_reg(REG_LENGTH_POS, 16'(pos_sel));
      write_reg(REG_LENGTH_WIDE, 16'(wide_sel));

      if (ph == 4 || ph == 18) hold_req <= ~hold_req;

      sent = 0;
      cur_dir = 1'($urandom_range(0, 1));
      while (sent < PHASE_ITEMS) begin
        if (ph == 20 && sent == PHASE_ITEMS / 2) wait_drained();
        if (mode_sel == MODE_TLV) begin
          send_tlv_frame(cur_dir, sent);
          if ($urandom_range(0, 7) == 0) cur_dir = ~cur_dir;
        end else begin
          if ($urandom_range(0, 19) == 0) cur_dir = ~cur_dir;
          b = 8'($urandom_range(0, 255));
          pick = $urandom_range(0, 9);
          if (mode_sel == MODE_DELIM && pick < 2) b = val_sel[7:0];
          if (mode_sel == MODE_CRLF) begin
            if (pick == 0) b = CHAR_CR;
            else if (pick == 1) b = CHAR_LF;
            else if (pick < 7) b = 8'($urandom_range(32, 126));
          end
          send_item(b, cur_dir, $urandom_range(0, 4) == 0, 1'b0, 2'd0, NO_RES, NO_RES);
          sent++;
        end
      end
    end

    wait_drained();
    $display("%0d bytes taken, %0d results checked, %0d register writes", items_taken,
             results_checked, reg_writes);
    $display("modes: chunk, delimiter, fixed count, tlv, cr/lf, unused codes; stalls and drains");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
